// ----- hw/rtl/atid_pkg.sv -----
// Shared types and constants for the APEv2 tag item deframer.
package atid_pkg;

  localparam int unsigned MaxTagBytesDefault = 1048576;
  localparam int unsigned MaxItemsDefault    = 65535;
  localparam int unsigned QueueDepth         = 2;

  typedef enum logic [2:0] {
    ROLE_HEADER  = 3'd0,
    ROLE_KEY     = 3'd1,
    ROLE_KEY_NUL = 3'd2,
    ROLE_VALUE   = 3'd3,
    ROLE_IGNORED = 3'd4
  } role_e;

  typedef enum logic [1:0] {
    ST_RUNNING = 2'd0,
    ST_DONE    = 2'd1,
    ST_FAILED  = 2'd2
  } status_e;

  localparam logic ADDR_REGION_SIZE = 1'b0;
  localparam logic ADDR_ITEM_COUNT  = 1'b1;

  // One byte as the front part hands it to the parser.
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       is_nul;
  } front_item_t;

  // One tagged byte as the parser delivers it.
  typedef struct packed {
    role_e       role;
    logic [7:0]  echo;
    logic [15:0] item;
    logic [1:0]  enc;
    logic [31:0] len;
    logic        done;
    status_e     status;
  } result_t;

  typedef struct packed {
    logic [20:0] region_size;
    logic [15:0] item_count;
  } cfg_t;

endpackage

// ----- hw/rtl/atid_fifo.sv -----
// Small register queue with push/full and pop/empty sides.
module atid_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ----- hw/rtl/atid_parse.sv -----
// Back part: walks the item structure one byte a cycle while the result queue has room, and tags each byte.
module atid_parse #(
  parameter int unsigned MAX_TAG_BYTES = atid_pkg::MaxTagBytesDefault,
  parameter int unsigned MAX_ITEMS     = atid_pkg::MaxItemsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  atid_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  input  atid_pkg::front_item_t in_item_i,
  output logic                in_take_o,
  input  logic                out_full_i,
  output logic                out_push_o,
  output atid_pkg::result_t   out_res_o
);
  import atid_pkg::*;

  localparam logic [1:0]  PH_HEAD  = 2'd0;
  localparam logic [1:0]  PH_KEY   = 2'd1;
  localparam logic [1:0]  PH_VALUE = 2'd2;
  localparam logic [20:0] PosMax   = '1;
  localparam logic [24:0] MaxTag   = 25'(MAX_TAG_BYTES);
  localparam logic [16:0] MaxItm   = 17'(MAX_ITEMS);

  logic [1:0]  phase_q, phase_d;
  logic [2:0]  hbc_q, hbc_d;
  logic [20:0] pos_q, pos_d;
  logic [31:0] size_q, size_d;
  logic [1:0]  enc_q, enc_d;
  logic [31:0] vleft_q, vleft_d;
  logic [15:0] seen_q, seen_d;
  status_e     stop_q, stop_d;
  logic        cfg_bad;
  logic        advance;

  assign cfg_bad = ((25'(cfg_i.region_size) + 25'd32) > MaxTag) ||
                   ({1'b0, cfg_i.item_count} > MaxItm);
  assign advance    = in_valid_i && !out_full_i;
  assign in_take_o  = advance;
  assign out_push_o = advance;

  function automatic status_e start_check(input logic [15:0] seen, input logic [20:0] at);
    logic [21:0] end_at;
    end_at = {1'b0, at} + 22'd10;
    if (seen >= cfg_i.item_count) begin
      return ST_DONE;
    end else if (cfg_bad || (end_at > {1'b0, cfg_i.region_size})) begin
      return ST_FAILED;
    end else begin
      return ST_RUNNING;
    end
  endfunction

  always_comb begin
    logic [1:0]  e_phase;
    logic [2:0]  e_hbc;
    logic [20:0] e_pos;
    logic [31:0] e_size;
    logic [1:0]  e_enc;
    logic [31:0] e_vleft;
    logic [15:0] e_seen;
    status_e     e_stop;
    logic [20:0] next_pos;
    logic [15:0] seen_inc;
    logic [20:0] room;
    logic [7:0]  b;
    logic [31:0] vdec;
    logic        finish;

    b = in_item_i.data;
    if (in_item_i.start) begin
      e_phase = PH_HEAD;
      e_hbc   = '0;
      e_pos   = '0;
      e_size  = '0;
      e_enc   = '0;
      e_vleft = '0;
      e_seen  = '0;
      e_stop  = ST_RUNNING;
    end else begin
      e_phase = phase_q;
      e_hbc   = hbc_q;
      e_pos   = pos_q;
      e_size  = size_q;
      e_enc   = enc_q;
      e_vleft = vleft_q;
      e_seen  = seen_q;
      e_stop  = stop_q;
    end

    next_pos = (e_pos == PosMax) ? e_pos : e_pos + 21'd1;
    seen_inc = (e_seen == 16'hFFFF) ? e_seen : e_seen + 16'd1;
    room     = cfg_i.region_size - e_pos - 21'd1;
    vdec     = (e_vleft != '0) ? e_vleft - 32'd1 : '0;
    finish   = 1'b0;

    phase_d = e_phase;
    hbc_d   = e_hbc;
    size_d  = e_size;
    enc_d   = e_enc;
    vleft_d = e_vleft;
    seen_d  = e_seen;
    stop_d  = e_stop;
    pos_d   = next_pos;

    out_res_o.role   = ROLE_IGNORED;
    out_res_o.echo   = b;
    out_res_o.item   = e_seen;
    out_res_o.enc    = '0;
    out_res_o.len    = '0;
    out_res_o.done   = 1'b0;

    // Check the item start before its first header byte.
    if (stop_d == ST_RUNNING && e_phase == PH_HEAD && e_hbc == '0) begin
      stop_d = start_check(e_seen, e_pos);
    end
    if (stop_d == ST_RUNNING && e_pos >= cfg_i.region_size) begin
      stop_d = ST_FAILED;
    end

    if (stop_d == ST_RUNNING) begin
      case (e_phase)
        PH_HEAD: begin
          out_res_o.role = ROLE_HEADER;
          if (e_hbc == '0) begin
            size_d = '0;
          end
          case (e_hbc)
            3'd0: size_d[7:0]   = b;
            3'd1: size_d[15:8]  = b;
            3'd2: size_d[23:16] = b;
            3'd3: size_d[31:24] = b;
            3'd4: enc_d         = b[2:1];
            default: ;
          endcase
          hbc_d = e_hbc + 3'd1;
          if (e_hbc == 3'd7) begin
            phase_d = PH_KEY;
          end
        end
        PH_KEY: begin
          out_res_o.enc = e_enc;
          out_res_o.len = e_size;
          if (!in_item_i.is_nul) begin
            out_res_o.role = ROLE_KEY;
            if (next_pos >= cfg_i.region_size || e_pos == PosMax) begin
              stop_d = ST_FAILED;
            end
          end else begin
            out_res_o.role = ROLE_KEY_NUL;
            if (e_size > 32'(room)) begin
              stop_d = ST_FAILED;
            end else if (e_size == '0) begin
              out_res_o.done = 1'b1;
              finish         = 1'b1;
            end else begin
              vleft_d = e_size;
              phase_d = PH_VALUE;
            end
          end
        end
        default: begin
          out_res_o.role = ROLE_VALUE;
          out_res_o.enc  = e_enc;
          out_res_o.len  = e_size;
          vleft_d        = vdec;
          if (vdec == '0) begin
            out_res_o.done = 1'b1;
            finish         = 1'b1;
          end
        end
      endcase
    end

    // Close the item and check where the next one would start.
    if (finish) begin
      seen_d  = seen_inc;
      phase_d = PH_HEAD;
      hbc_d   = '0;
      stop_d  = start_check(seen_inc, next_pos);
    end

    out_res_o.status = stop_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD;
      hbc_q   <= '0;
      pos_q   <= '0;
      size_q  <= '0;
      enc_q   <= '0;
      vleft_q <= '0;
      seen_q  <= '0;
      stop_q  <= ST_RUNNING;
    end else if (advance) begin
      phase_q <= phase_d;
      hbc_q   <= hbc_d;
      pos_q   <= pos_d;
      size_q  <= size_d;
      enc_q   <= enc_d;
      vleft_q <= vleft_d;
      seen_q  <= seen_d;
      stop_q  <= stop_d;
    end
  end

endmodule

// ----- hw/rtl/ape_tag_item_deframer_core.sv -----
// Top level of the APEv2 tag item deframer: register port, queues and parser.
// Path: a byte accepted into the front queue is parsed at the queue head and its result
//   is written into the result queue and shown on the result ports (empty low); a full
//   result queue holds the parse back for as long as the consumer stalls.
// Throughput: one byte per cycle while the result queue has room.
// Reset: rst_ni clears both queues, the parse state and the registers at once;
//   no clearing pass is needed and bytes are accepted from the first cycle.
module ape_tag_item_deframer_core #(
  parameter int unsigned MAX_TAG_BYTES = atid_pkg::MaxTagBytesDefault,
  parameter int unsigned MAX_ITEMS     = atid_pkg::MaxItemsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // byte input
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        region_start_i,
  // tagged byte output
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  byte_role_o,
  output logic [7:0]  echo_byte_o,
  output logic [15:0] item_number_o,
  output logic [1:0]  value_encoding_o,
  output logic [31:0] value_length_o,
  output logic        value_done_o,
  output logic [1:0]  parse_status_o
);
  import atid_pkg::*;

  cfg_t        cfg_q, cfg_d;
  logic        cfg_wr;
  front_item_t front_in, front_out;
  logic        front_empty, front_take;
  result_t     res_in, res_out;
  logic        res_full, res_push;

  // Registers: written on the access phase of a write request.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (paddr[2])
        ADDR_REGION_SIZE: cfg_d.region_size = pwdata[20:0];
        ADDR_ITEM_COUNT:  cfg_d.item_count  = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      ADDR_REGION_SIZE: prdata = {11'd0, cfg_q.region_size};
      ADDR_ITEM_COUNT:  prdata = {16'd0, cfg_q.item_count};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: classify the byte (key terminator) and hold it in a short queue so
  // the parser and the producer stall independently.
  assign front_in.data   = data_byte_i;
  assign front_in.start  = region_start_i;
  assign front_in.is_nul = (data_byte_i == 8'd0);

  atid_fifo #(
    .WIDTH ($bits(front_item_t)),
    .DEPTH (QueueDepth)
  ) u_front_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_in),
    .full_o  (full),
    .pop_i   (front_take),
    .rdata_o (front_out),
    .empty_o (front_empty)
  );

  // Back: advance the parse whenever a byte waits and the result queue has room.
  atid_parse #(
    .MAX_TAG_BYTES (MAX_TAG_BYTES),
    .MAX_ITEMS     (MAX_ITEMS)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (!front_empty),
    .in_item_i  (front_out),
    .in_take_o  (front_take),
    .out_full_i (res_full),
    .out_push_o (res_push),
    .out_res_o  (res_in)
  );

  // Result queue: hold finished results until the consumer pops them.
  atid_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QueueDepth)
  ) u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign byte_role_o      = res_out.role;
  assign echo_byte_o      = res_out.echo;
  assign item_number_o    = res_out.item;
  assign value_encoding_o = res_out.enc;
  assign value_length_o   = res_out.len;
  assign value_done_o     = res_out.done;
  assign parse_status_o   = res_out.status;

endmodule
